[src/pfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types, constants and helpers for the particle sensor frame parser.
// ----------------------------------------------------------------------------
package pfp_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 32;
  localparam int POS_W       = 6;
  localparam logic [POS_W-1:0] POS_MAX      = 6'd63;
  localparam logic [POS_W-1:0] POS_HEAD0    = 6'd0;
  localparam logic [POS_W-1:0] POS_HEAD1    = 6'd1;
  localparam logic [POS_W-1:0] POS_SUM_FROM = 6'd2;
  localparam logic [POS_W-1:0] POS_LAST_MIN = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0]  HEAD0     = 8'h42;
  localparam logic [7:0]  HEAD1     = 8'h4D;
  localparam logic [15:0] SUM_RESET = 16'h0000;

  // Capture slots: bytes 6..19 in slots 0..13, bytes 28..31 in slots 14..17
  localparam int CAP_DEPTH    = 18;
  localparam int CAP_LO_FIRST = 6;
  localparam int CAP_LO_COUNT = 14;
  localparam int CAP_HI_FIRST = 28;

  // Slot indexes of the reported fields (high byte of each word)
  localparam int SLOT_PM25_STD = 0;
  localparam int SLOT_PM1_AMB  = 4;
  localparam int SLOT_PM25_AMB = 6;
  localparam int SLOT_PM10_AMB = 8;
  localparam int SLOT_CNT_SM   = 10;
  localparam int SLOT_CNT_MD   = 12;
  localparam int SLOT_FW       = 14;
  localparam int SLOT_ERR      = 15;
  localparam int SLOT_CHK      = 16;

  // Buffer position that lands in a given capture slot
  function automatic logic [POS_W-1:0] cap_pos(input int slot);
    int pos;
    if (slot < CAP_LO_COUNT) begin
      pos = CAP_LO_FIRST + slot;
    end else begin
      pos = CAP_HI_FIRST + slot - CAP_LO_COUNT;
    end
    return POS_W'(pos);
  endfunction

  // One result transaction
  typedef struct packed {
    logic        frame_valid;
    logic [15:0] pm25_standard;
    logic [15:0] pm1_ambient;
    logic [15:0] pm25_ambient;
    logic [15:0] pm10_ambient;
    logic [15:0] count_small;
    logic [15:0] count_medium;
    logic [7:0]  firmware_version;
    logic [7:0]  error_code;
  } pfp_result_t;

  // Control between the input stage and the frame core
  typedef struct packed {
    logic       step;
    logic       last_byte;
    logic [7:0] data_byte;
  } pfp_step_t;

endpackage
`default_nettype wire

[src/pfp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_byte_if / pfp_result_if
// Valid/ready channels for received bytes and parsed frame results.
// ----------------------------------------------------------------------------
interface pfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pfp_result_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic [15:0] pm25_standard;
  logic [15:0] pm1_ambient;
  logic [15:0] pm25_ambient;
  logic [15:0] pm10_ambient;
  logic [15:0] count_small;
  logic [15:0] count_medium;
  logic [7:0]  firmware_version;
  logic [7:0]  error_code;

  modport source (
    output valid, output frame_valid, output pm25_standard, output pm1_ambient,
    output pm25_ambient, output pm10_ambient, output count_small,
    output count_medium, output firmware_version, output error_code,
    input ready
  );
  modport sink (
    input valid, input frame_valid, input pm25_standard, input pm1_ambient,
    input pm25_ambient, input pm10_ambient, input count_small,
    input count_medium, input firmware_version, input error_code,
    output ready
  );
endinterface
`default_nettype wire

[src/pfp_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_in_stage
// Input register for received bytes; releases a byte to the frame core when
// the core can take it (a final byte needs a free result register).
// ----------------------------------------------------------------------------
module pfp_in_stage import pfp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic       res_free,
  output pfp_step_t       step_o,
  output logic            hold_o
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       advance;

  // Advance a held byte unless it closes a frame and the result is blocked
  assign advance  = valid_r && (!last_r || res_free);
  assign in_ready = !valid_r || advance;
  assign hold_o   = valid_r && !advance;

  assign step_o.step      = advance;
  assign step_o.last_byte = last_r;
  assign step_o.data_byte = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on each accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

endmodule
`default_nettype wire

[src/pfp_frame_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_frame_core
// Per-frame state: byte position, checksum accumulator, header check and
// captured field bytes. Builds the result for the final byte of a buffer.
// ----------------------------------------------------------------------------
module pfp_frame_core import pfp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pfp_step_t step_i,
  output pfp_result_t    result_o
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       dly0_r, dly1_r;
  logic             hdr_r, hdr_nxt;
  logic [7:0]       cap_r   [CAP_DEPTH];
  logic [7:0]       cap_nxt [CAP_DEPTH];
  logic [15:0]      chk_word;

  // Next state for this byte
  always_comb begin
    sum_nxt = sum_r;
    if (pos_r >= POS_SUM_FROM) begin
      sum_nxt = sum_r + {8'h00, dly1_r};
    end
    hdr_nxt = hdr_r;
    if (pos_r == POS_HEAD0 && step_i.data_byte != HEAD0) begin
      hdr_nxt = 1'b0;
    end
    if (pos_r == POS_HEAD1 && step_i.data_byte != HEAD1) begin
      hdr_nxt = 1'b0;
    end
    for (int i = 0; i < CAP_DEPTH; i++) begin
      cap_nxt[i] = (pos_r == cap_pos(i)) ? step_i.data_byte : cap_r[i];
    end
    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  end

  // Build the result from the updated state
  assign chk_word = {cap_nxt[SLOT_CHK], cap_nxt[SLOT_CHK+1]};

  always_comb begin
    result_o.frame_valid      = (pos_r >= POS_LAST_MIN) && hdr_nxt && (sum_nxt == chk_word);
    result_o.pm25_standard    = {cap_nxt[SLOT_PM25_STD], cap_nxt[SLOT_PM25_STD+1]};
    result_o.pm1_ambient      = {cap_nxt[SLOT_PM1_AMB], cap_nxt[SLOT_PM1_AMB+1]};
    result_o.pm25_ambient     = {cap_nxt[SLOT_PM25_AMB], cap_nxt[SLOT_PM25_AMB+1]};
    result_o.pm10_ambient     = {cap_nxt[SLOT_PM10_AMB], cap_nxt[SLOT_PM10_AMB+1]};
    result_o.count_small      = {cap_nxt[SLOT_CNT_SM], cap_nxt[SLOT_CNT_SM+1]};
    result_o.count_medium     = {cap_nxt[SLOT_CNT_MD], cap_nxt[SLOT_CNT_MD+1]};
    result_o.firmware_version = cap_nxt[SLOT_FW];
    result_o.error_code       = cap_nxt[SLOT_ERR];
  end

  // Advance state on each byte; drop back to the start after a final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= SUM_RESET;
      dly0_r <= 8'h00;
      dly1_r <= 8'h00;
      hdr_r  <= 1'b1;
      for (int i = 0; i < CAP_DEPTH; i++) begin
        cap_r[i] <= 8'h00;
      end
    end else if (step_i.step) begin
      if (step_i.last_byte) begin
        pos_r  <= '0;
        sum_r  <= SUM_RESET;
        dly0_r <= 8'h00;
        dly1_r <= 8'h00;
        hdr_r  <= 1'b1;
        for (int i = 0; i < CAP_DEPTH; i++) begin
          cap_r[i] <= 8'h00;
        end
      end else begin
        pos_r  <= pos_nxt;
        sum_r  <= sum_nxt;
        dly0_r <= step_i.data_byte;
        dly1_r <= dly0_r;
        hdr_r  <= hdr_nxt;
        for (int i = 0; i < CAP_DEPTH; i++) begin
          cap_r[i] <= cap_nxt[i];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step_i.step && step_i.last_byte |=> pos_r == '0 && hdr_r && sum_r == SUM_RESET)
    else $error("frame state not restarted after final byte");

  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    step_i.step && step_i.last_byte && result_o.frame_valid |-> pos_r >= POS_LAST_MIN)
    else $error("short buffer flagged valid");

  a_bad_head: assert property (@(posedge clk) disable iff (!rst_n)
    step_i.step && !step_i.last_byte && pos_r == POS_HEAD0 && step_i.data_byte != HEAD0
    |=> !hdr_r)
    else $error("bad first header byte not recorded");
`endif

endmodule
`default_nettype wire

[src/pfp_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_out_reg
// Result register: holds one parsed frame until the sink takes it.
// ----------------------------------------------------------------------------
module pfp_out_reg import pfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire pfp_result_t result_i,
  output logic             free_o,
  output logic             out_valid,
  input  wire logic        out_ready,
  output pfp_result_t      result_o
);

  logic        valid_r, valid_nxt;
  pfp_result_t res_r;

  assign free_o    = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign result_o  = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold valid until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load a new result
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result_i;
    end
  end

endmodule
`default_nettype wire

[src/particle_sensor_frame_parser_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser_top
// Parses 32-byte particle sensor frames from a byte stream and reports the
// checksum/header verdict with the measurement fields.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle with no gaps needed between
// buffers. A byte is held in the input register, then the frame core
// updates position, checksum and captured fields in one pass; the result for
// a final byte is built from the updated state and loaded into the result
// register. Only a final byte ever waits: it needs the result register free,
// so a stalled result sink holds the stream only when the next frame ends.
// No clearing pass after reset; the block takes bytes at once.
module particle_sensor_frame_parser_top import pfp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  pfp_byte_if.sink      in_if,
  pfp_result_if.source  out_if
);

  pfp_step_t   step;
  pfp_result_t core_res;
  pfp_result_t out_res;
  logic        res_free;
  logic        in_hold;

  // Input register
  pfp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_data_byte (in_if.data_byte),
    .in_last_byte (in_if.last_byte),
    .res_free     (res_free),
    .step_o       (step),
    .hold_o       (in_hold)
  );

  // Frame state and result build
  pfp_frame_core u_frame_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .result_o (core_res)
  );

  // Result register
  pfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step.step && step.last_byte),
    .result_i  (core_res),
    .free_o    (res_free),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .result_o  (out_res)
  );

  assign out_if.frame_valid      = out_res.frame_valid;
  assign out_if.pm25_standard    = out_res.pm25_standard;
  assign out_if.pm1_ambient      = out_res.pm1_ambient;
  assign out_if.pm25_ambient     = out_res.pm25_ambient;
  assign out_if.pm10_ambient     = out_res.pm10_ambient;
  assign out_if.count_small      = out_res.count_small;
  assign out_if.count_medium     = out_res.count_medium;
  assign out_if.firmware_version = out_res.firmware_version;
  assign out_if.error_code       = out_res.error_code;

`ifndef SYNTHESIS
  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_hold |-> step.last_byte && out_if.valid && !out_if.ready)
    else $error("byte held without a blocked result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> !$past(step.step && step.last_byte) || $past(res_free))
    else $error("pending result overwritten");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    step.step && step.last_byte |=> out_if.valid)
    else $error("final byte produced no result");
`endif

endmodule
`default_nettype wire
